>>> rtl/legendre_multipole_bin_accumulator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Legendre multipole bin accumulator
// Shared property wrappers; they expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef LEGENDRE_MULTIPOLE_BIN_ACCUMULATOR_MACROS_SVH
`define LEGENDRE_MULTIPOLE_BIN_ACCUMULATOR_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define LMBA_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger is followed in the next cycle by a consequence.
`define LMBA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/lmba_pkg.sv
// ----------------------------------------------------------------------------
// lmba_pkg
// Types, constants and coefficient tables of the multipole accumulator.
// ----------------------------------------------------------------------------
package lmba_pkg;

  localparam int unsigned DIV_STEPS = 30;
  localparam int unsigned MUL_STEPS = 24;
  localparam int unsigned N_TERMS   = 15;
  localparam int unsigned N_POLES   = 5;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  localparam logic CFG_LIN_BINS = 1'b0;
  localparam logic CFG_LOG_BINS = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_TERM,
    ST_SCALE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic signed [15:0] coef;
    logic [2:0]         k;     // 0: wn, 1..4: C2..C8
    logic               last;
  } term_t;

  // Integer Legendre combinations, one product a step, grouped by l.
  function automatic term_t term_entry(input logic [3:0] idx);
    term_t t;
    t = '{coef: 16'sd0, k: 3'd0, last: 1'b0};
    case (idx)
      4'd0:  t = '{coef:  16'sd1,     k: 3'd0, last: 1'b1};
      4'd1:  t = '{coef:  16'sd3,     k: 3'd1, last: 1'b0};
      4'd2:  t = '{coef: -16'sd1,     k: 3'd0, last: 1'b1};
      4'd3:  t = '{coef:  16'sd35,    k: 3'd2, last: 1'b0};
      4'd4:  t = '{coef: -16'sd30,    k: 3'd1, last: 1'b0};
      4'd5:  t = '{coef:  16'sd3,     k: 3'd0, last: 1'b1};
      4'd6:  t = '{coef:  16'sd231,   k: 3'd3, last: 1'b0};
      4'd7:  t = '{coef: -16'sd315,   k: 3'd2, last: 1'b0};
      4'd8:  t = '{coef:  16'sd105,   k: 3'd1, last: 1'b0};
      4'd9:  t = '{coef: -16'sd5,     k: 3'd0, last: 1'b1};
      4'd10: t = '{coef:  16'sd6435,  k: 3'd4, last: 1'b0};
      4'd11: t = '{coef: -16'sd12012, k: 3'd3, last: 1'b0};
      4'd12: t = '{coef:  16'sd6930,  k: 3'd2, last: 1'b0};
      4'd13: t = '{coef: -16'sd1260,  k: 3'd1, last: 1'b0};
      4'd14: t = '{coef:  16'sd35,    k: 3'd0, last: 1'b1};
      default: t = '{coef: 16'sd0, k: 3'd0, last: 1'b1};
    endcase
    return t;
  endfunction

  // (2l+1)/2^m scale numerators and shifts per multipole.
  function automatic logic [4:0] scale_num(input logic [2:0] grp);
    logic [4:0] n;
    case (grp)
      3'd0:    n = 5'd1;
      3'd1:    n = 5'd5;
      3'd2:    n = 5'd9;
      3'd3:    n = 5'd13;
      3'd4:    n = 5'd17;
      default: n = 5'd1;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] scale_shift(input logic [2:0] grp);
    logic [2:0] s;
    case (grp)
      3'd0:    s = 3'd0;
      3'd1:    s = 3'd1;
      3'd2:    s = 3'd3;
      3'd3:    s = 3'd4;
      3'd4:    s = 3'd7;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/legendre_multipole_bin_accumulator.sv
// ----------------------------------------------------------------------------
// legendre_multipole_bin_accumulator
// Even Legendre multipoles (l = 0..8) of fine pair-count bins, per log r bin.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (in_valid/in_ready) carry one fine (log r, mu) bin each, in
//   row order. Every lin_bins words close one log r bin and yield one output
//   word (out_valid/out_ready) with the log bin index, the five saturated
//   Q48.16 multipole sums and a flag set if any sum clipped.
//   Registers lin_bins (index 0) and log_bins (index 1) are written through
//   cfg_we/cfg_index/cfg_wdata; the user must write them only while
//   idle; the block does not enforce it. 0 acts as 1, above max as max.
// Sequence:
//   A word needs a divide unless its pair count or weight is zero (mu = 0)
//   or |mu sum| is not below the weight (mu clamped to one). With a divide
//   a word passes the serial divider (30 quotient bits plus the handoff),
//   then the shared 31x31 multiplier for mu powers and C_k, 15 constant
//   MACs and 5 scale/accumulate steps; it then retires and the block goes
//   back to idle. Without a divide the divider is skipped. The result of a
//   bin's last word is loaded into the output register as it retires.
//   in_ready is high only when idle. A finished result sits in the output
//   register; the next word is taken meanwhile, and the block holds in
//   retire only if a second result is due before the first was taken.
// Reset:
//   Synchronous, active low. Clears sums, positions and the clip flag and
//   loads lin_bins = 16, log_bins = 32.
// ----------------------------------------------------------------------------
`include "legendre_multipole_bin_accumulator_macros.svh"

module legendre_multipole_bin_accumulator #(
  parameter int unsigned MAX_LIN_BINS = 64,
  parameter int unsigned MAX_LOG_BINS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_pair_count,
  input  logic [47:0]        in_weighted_count,
  input  logic signed [48:0] in_weighted_mu_sum,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         out_log_bin_index,
  output logic signed [63:0] out_multipole_l0,
  output logic signed [63:0] out_multipole_l2,
  output logic signed [63:0] out_multipole_l4,
  output logic signed [63:0] out_multipole_l6,
  output logic signed [63:0] out_multipole_l8,
  output logic               out_saturated,
  // configuration
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_wdata
);

  localparam int unsigned LIN_W = $clog2(MAX_LIN_BINS + 1);
  localparam int unsigned LOG_W = $clog2(MAX_LOG_BINS + 1);

  lmba_pkg::state_t    state_r, state_nxt;
  lmba_pkg::div_stat_t div_stat;
  lmba_pkg::term_t     term;

  logic [6:0]        lin_cfg_r, log_cfg_r;
  logic [LIN_W-1:0]  lin_pos_r, lin_pos_nxt;
  logic [LOG_W-1:0]  log_pos_r, log_pos_nxt;
  logic              clip_r, clip_nxt;
  logic signed [63:0] acc_r [lmba_pkg::N_POLES];
  logic signed [63:0] acc_nxt [lmba_pkg::N_POLES];

  logic [47:0] wn_r;
  logic [30:0] mu_r, mu_nxt;
  logic [30:0] pw_r [4];
  logic [47:0] c_r [4];
  logic [54:0] hi_r;
  logic [61:0] prod_r;
  logic signed [63:0] s_r, s_nxt;
  logic [4:0]  step_r, step_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [2:0]  grp_r, grp_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        load_out;

  logic        accept, div_start;
  logic [48:0] wmag;
  logic [30:0] mul_a, mul_b;
  logic [3:0]  op;
  logic [3:0]  cop;
  logic [1:0]  cj;
  logic [47:0] c_sel;
  logic signed [64:0] mac_prod;
  logic signed [69:0] s_ext, n_ext, sp, sp_sh;
  logic signed [63:0] v, sum;
  logic        ovf;
  logic [8:0]  elin, elog, lin9, log9, lpos1, gpos1;
  logic [55:0] lo_sum;
  logic [29:0] div_q;
  logic        mu_live;
  logic        bin_clear;

  lmba_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (wmag[47:0]),
    .den   (in_weighted_count),
    .stat  (div_stat),
    .quot  (div_q)
  );

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == lmba_pkg::ST_IDLE);

  // |mu sum| in 49 bits; the most negative value has magnitude 2^48
  assign wmag = in_weighted_mu_sum[48] ? 49'(-in_weighted_mu_sum) : in_weighted_mu_sum;
  assign div_start = accept && (in_pair_count != '0) && (in_weighted_count != '0)
                     && (wmag < {1'b0, in_weighted_count});

  // Effective bin counts: zero acts as one, clamp to the maximum
  always_comb begin
    lin9 = {2'b00, lin_cfg_r};
    log9 = {2'b00, log_cfg_r};
    elin = (lin9 == '0) ? 9'd1 : (lin9 > 9'(MAX_LIN_BINS)) ? 9'(MAX_LIN_BINS) : lin9;
    elog = (log9 == '0) ? 9'd1 : (log9 > 9'(MAX_LOG_BINS)) ? 9'(MAX_LOG_BINS) : log9;
    lpos1 = 9'(lin_pos_r) + 9'd1;
    gpos1 = 9'(log_pos_r) + 9'd1;
  end

  // Shared multiplier operands: powers first, then wn high/low halves by m_k
  always_comb begin
    op  = step_r[4:1];
    cop = op - 4'd4;
    cj  = cop[2:1];
    mul_a = '0;
    mul_b = '0;
    case (op)
      4'd0: begin
        mul_a = mu_r;
        mul_b = mu_r;
      end
      4'd1: begin
        mul_a = pw_r[0];
        mul_b = pw_r[0];
      end
      4'd2: begin
        mul_a = pw_r[1];
        mul_b = pw_r[0];
      end
      4'd3: begin
        mul_a = pw_r[1];
        mul_b = pw_r[1];
      end
      default: begin
        mul_a = cop[0] ? {7'b0, wn_r[23:0]} : {7'b0, wn_r[47:24]};
        mul_b = pw_r[cj];
      end
    endcase
  end

  // Low-half recombination of floor(wn * m / 2^30)
  assign lo_sum = {1'b0, hi_r[5:0], 24'b0} + {1'b0, prod_r[54:0]};

  // Constant MAC and scaling
  assign term = lmba_pkg::term_entry(idx_r);
  always_comb begin
    case (term.k)
      3'd0:    c_sel = wn_r;
      3'd1:    c_sel = c_r[0];
      3'd2:    c_sel = c_r[1];
      3'd3:    c_sel = c_r[2];
      3'd4:    c_sel = c_r[3];
      default: c_sel = wn_r;
    endcase
    mac_prod = 65'(term.coef) * $signed({17'b0, c_sel});
    s_ext = 70'(s_r);
    n_ext = $signed({65'b0, lmba_pkg::scale_num(grp_r)});
    sp    = s_ext * n_ext;
    sp_sh = sp >>> lmba_pkg::scale_shift(grp_r);
    v     = sp_sh[63:0];
    sum   = acc_r[grp_r] + v;
    ovf   = (acc_r[grp_r][63] == v[63]) && (sum[63] != v[63]);
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    mu_nxt        = mu_r;
    step_nxt      = step_r;
    idx_nxt       = idx_r;
    grp_nxt       = grp_r;
    s_nxt         = s_r;
    lin_pos_nxt   = lin_pos_r;
    log_pos_nxt   = log_pos_r;
    clip_nxt      = clip_r;
    out_valid_nxt = out_valid_r && !out_ready;
    load_out      = 1'b0;
    for (int i = 0; i < lmba_pkg::N_POLES; i++) begin
      acc_nxt[i] = acc_r[i];
    end
    case (state_r)
      lmba_pkg::ST_IDLE: begin
        if (accept) begin
          step_nxt = '0;
          idx_nxt  = '0;
          grp_nxt  = '0;
          s_nxt    = '0;
          if (div_start) begin
            state_nxt = lmba_pkg::ST_DIV;
          end else begin
            // zero count or weight gives mu = 0; beyond weight clamps to one
            mu_nxt = ((in_pair_count == '0) || (in_weighted_count == '0)) ? '0
                     : lmba_pkg::ONE_Q30;
            state_nxt = lmba_pkg::ST_MUL;
          end
        end
      end
      lmba_pkg::ST_DIV: begin
        if (div_stat.done) begin
          mu_nxt    = {1'b0, div_q};
          state_nxt = lmba_pkg::ST_MUL;
        end
      end
      lmba_pkg::ST_MUL: begin
        step_nxt = step_r + 5'd1;
        if (step_r == 5'(lmba_pkg::MUL_STEPS - 1)) begin
          state_nxt = lmba_pkg::ST_TERM;
        end
      end
      lmba_pkg::ST_TERM: begin
        s_nxt = s_r + mac_prod[63:0];
        if (term.last) begin
          state_nxt = lmba_pkg::ST_SCALE;
        end else begin
          idx_nxt = idx_r + 4'd1;
        end
      end
      lmba_pkg::ST_SCALE: begin
        if (ovf) begin
          acc_nxt[grp_r] = v[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
          clip_nxt       = 1'b1;
        end else begin
          acc_nxt[grp_r] = sum;
        end
        s_nxt   = '0;
        idx_nxt = idx_r + 4'd1;
        grp_nxt = grp_r + 3'd1;
        state_nxt = (grp_r == 3'(lmba_pkg::N_POLES - 1)) ? lmba_pkg::ST_DONE
                                                          : lmba_pkg::ST_TERM;
      end
      lmba_pkg::ST_DONE: begin
        if (lpos1 < elin) begin
          lin_pos_nxt = LIN_W'(lpos1);
          state_nxt   = lmba_pkg::ST_IDLE;
        end else if (!(out_valid_r && !out_ready)) begin
          // emit: hand the sums to the output register and restart the bin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          for (int i = 0; i < lmba_pkg::N_POLES; i++) begin
            acc_nxt[i] = '0;
          end
          clip_nxt    = 1'b0;
          lin_pos_nxt = '0;
          log_pos_nxt = (gpos1 >= elog) ? '0 : LOG_W'(gpos1);
          state_nxt   = lmba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lmba_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lmba_pkg::ST_IDLE;
      lin_cfg_r   <= 7'd16;
      log_cfg_r   <= 7'd32;
      lin_pos_r   <= '0;
      log_pos_r   <= '0;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      idx_r       <= '0;
      grp_r       <= '0;
      for (int i = 0; i < lmba_pkg::N_POLES; i++) begin
        acc_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      lin_pos_r   <= lin_pos_nxt;
      log_pos_r   <= log_pos_nxt;
      clip_r      <= clip_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
      idx_r       <= idx_nxt;
      grp_r       <= grp_nxt;
      for (int i = 0; i < lmba_pkg::N_POLES; i++) begin
        acc_r[i] <= acc_nxt[i];
      end
      if (cfg_we) begin
        if (cfg_index == lmba_pkg::CFG_LIN_BINS) begin
          lin_cfg_r <= cfg_wdata;
        end else begin
          log_cfg_r <= cfg_wdata;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    mu_r <= mu_nxt;
    s_r  <= s_nxt;
    if (accept) begin
      wn_r <= in_weighted_count;
    end
    if (state_r == lmba_pkg::ST_MUL) begin
      if (!step_r[0]) begin
        prod_r <= 62'(mul_a * mul_b);
      end else if (op < 4'd4) begin
        pw_r[op[1:0]] <= prod_r[60:30];
      end else if (!cop[0]) begin
        hi_r <= prod_r[54:0];
      end else begin
        c_r[cj] <= 48'(49'(hi_r >> 6) + 49'(lo_sum >> 30));
      end
    end
    if (load_out) begin
      out_log_bin_index <= 6'(log_pos_r);
      out_multipole_l0  <= acc_r[0];
      out_multipole_l2  <= acc_r[1];
      out_multipole_l4  <= acc_r[2];
      out_multipole_l6  <= acc_r[3];
      out_multipole_l8  <= acc_r[4];
      out_saturated     <= clip_r;
    end
  end

  assign out_valid = out_valid_r;

  // mu is only meaningful once the multiply phase has started
  assign mu_live   = (state_r != lmba_pkg::ST_IDLE) && (state_r != lmba_pkg::ST_DIV);
  assign bin_clear = (acc_r[0] == '0) && !clip_r && (lin_pos_r == '0);

  `LMBA_ASSERT(a_mu_le_one, !mu_live || (mu_r <= lmba_pkg::ONE_Q30), "mu above one")
  `LMBA_ASSERT(a_div_only_in_div, !div_stat.busy || (state_r == lmba_pkg::ST_DIV), "divider busy")
  `LMBA_ASSERT_NEXT(a_emit_clears, load_out, bin_clear, "bin not cleared after emit")
  `LMBA_ASSERT_NEXT(a_emit_valid, load_out, out_valid_r, "emitted result not presented")

endmodule

>>> rtl/lmba_div.sv
// ----------------------------------------------------------------------------
// lmba_div
// Restoring divider: one quotient bit a cycle, Q0.30 fraction of num/den.
// ----------------------------------------------------------------------------
module lmba_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [47:0]             num,
  input  logic [47:0]             den,
  output lmba_pkg::div_stat_t     stat,
  output logic [29:0]             quot
);

  logic [47:0] rem_r, rem_nxt;
  logic [47:0] den_r;
  logic [29:0] q_r, q_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [48:0] rem2;

  always_comb begin
    rem2     = {rem_r, 1'b0};
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num;
      q_nxt    = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // rem stays below den, so the doubled value fits 49 bits
      if (rem2 >= {1'b0, den_r}) begin
        rem_nxt = 48'(rem2 - {1'b0, den_r});
        q_nxt   = {q_r[28:0], 1'b1};
      end else begin
        rem_nxt = rem2[47:0];
        q_nxt   = {q_r[28:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(lmba_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = q_r;

endmodule

>>> sim/legendre_multipole_bin_accumulator_checker.sv
// ----------------------------------------------------------------------------
// Multipole accumulator checker
// Watches the input, result and configuration ports, predicts each log bin
// result and compares it field by field with what the block delivers.
// ----------------------------------------------------------------------------
module legendre_multipole_bin_accumulator_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [31:0]        in_pair_count,
  input  logic [47:0]        in_weighted_count,
  input  logic signed [48:0] in_weighted_mu_sum,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [5:0]         out_log_bin_index,
  input  logic signed [63:0] out_multipole_l0,
  input  logic signed [63:0] out_multipole_l2,
  input  logic signed [63:0] out_multipole_l4,
  input  logic signed [63:0] out_multipole_l6,
  input  logic signed [63:0] out_multipole_l8,
  input  logic               out_saturated,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_wdata,
  output int                 fail_count,
  output int                 pending_count,
  output int                 results_seen,
  output int                 words_seen
);

  localparam int LIN_MAX = 64;
  localparam int LOG_MAX = 64;

  typedef struct {
    logic [5:0]  bin;
    longint      pole[5];
    logic        clip;
  } multipole_bin_t;

  multipole_bin_t expected_bins[$];
  logic [6:0]     lin_bins_reg;
  logic [6:0]     log_bins_reg;
  longint         pole_sums[5];
  int             lin_pos;
  int             log_pos;
  logic           clip_seen;
  int             fails;
  int             n_results;
  int             n_words;

  initial begin
    fails = 0;
    n_results = 0;
    n_words = 0;
    fail_count = 0;
    pending_count = 0;
    results_seen = 0;
    words_seen = 0;
  end

  // Restoring division: floor(mag * 2^30 / wn), mag < wn.
  function automatic logic [63:0] mu_ratio(logic [63:0] mag, logic [63:0] wn);
    logic [63:0] rem;
    logic [63:0] q;
    rem = mag;
    q = 0;
    for (int i = 0; i < 30; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= wn) begin
        rem = rem - wn;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic longint weight_by_mu(logic [47:0] wn, logic [63:0] m);
    logic [79:0] p;
    p = 80'(wn) * 80'(m);
    return longint'(p >> 30);
  endfunction

  // floor(s * num / 2^sh) without overflowing the product.
  function automatic longint legendre_scale(longint s, longint num, int sh);
    longint q;
    longint r;
    if (sh == 0) return s * num;
    q = s >>> sh;
    r = s - (q <<< sh);
    return q * num + ((r * num) >>> sh);
  endfunction

  function automatic int clamp_bins(logic [6:0] v, int hi);
    if (v == 0) return 1;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  task automatic add_clipped(int k, longint v);
    logic signed [64:0] t;
    t = 65'(pole_sums[k]) + 65'(v);
    if (t > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
      pole_sums[k] = 64'h7FFF_FFFF_FFFF_FFFF;
      clip_seen = 1'b1;
    end else if (t < -65'sh0_8000_0000_0000_0000) begin
      pole_sums[k] = 64'h8000_0000_0000_0000;
      clip_seen = 1'b1;
    end else begin
      pole_sums[k] = longint'(t);
    end
  endtask

  task automatic predict_word(logic [31:0] n, logic [47:0] wn, logic [48:0] wmu);
    logic [63:0]    mag;
    logic [63:0]    m, m2, m4, m6, m8;
    longint         c0, c2, c4, c6, c8;
    multipole_bin_t res;
    mag = wmu[48] ? ((64'd1 << 49) - 64'(wmu)) : 64'(wmu);
    m = 0;
    if (n != 0 && wn != 0) m = (mag >= 64'(wn)) ? (64'd1 << 30) : mu_ratio(mag, 64'(wn));
    m2 = (m * m) >> 30;
    m4 = (m2 * m2) >> 30;
    m6 = (m4 * m2) >> 30;
    m8 = (m4 * m4) >> 30;
    c0 = longint'(wn);
    c2 = weight_by_mu(wn, m2);
    c4 = weight_by_mu(wn, m4);
    c6 = weight_by_mu(wn, m6);
    c8 = weight_by_mu(wn, m8);
    add_clipped(0, c0);
    add_clipped(1, legendre_scale(3 * c2 - c0, 5, 1));
    add_clipped(2, legendre_scale(35 * c4 - 30 * c2 + 3 * c0, 9, 3));
    add_clipped(3, legendre_scale(231 * c6 - 315 * c4 + 105 * c2 - 5 * c0, 13, 4));
    add_clipped(4, legendre_scale(6435 * c8 - 12012 * c6 + 6930 * c4 - 1260 * c2
                                  + 35 * c0, 17, 7));
    if (lin_pos + 1 < clamp_bins(lin_bins_reg, LIN_MAX)) begin
      lin_pos++;
      return;
    end
    res.bin = 6'(log_pos);
    res.pole = pole_sums;
    res.clip = clip_seen;
    expected_bins.push_back(res);
    for (int k = 0; k < 5; k++) pole_sums[k] = 0;
    clip_seen = 1'b0;
    lin_pos = 0;
    log_pos = (log_pos + 1 >= clamp_bins(log_bins_reg, LOG_MAX)) ? 0 : log_pos + 1;
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch %s: got %h, expected %h", $realtime, what, got, want);
    fails++;
  endtask

  task automatic check_result();
    multipole_bin_t want;
    longint         got[5];
    if (expected_bins.size() == 0) begin
      report_mismatch("unexpected result word", 64'(out_log_bin_index), 0);
      return;
    end
    want = expected_bins.pop_front();
    got = '{out_multipole_l0, out_multipole_l2, out_multipole_l4,
            out_multipole_l6, out_multipole_l8};
    if (out_log_bin_index !== want.bin)
      report_mismatch("log_bin_index", 64'(out_log_bin_index), 64'(want.bin));
    for (int k = 0; k < 5; k++)
      if (got[k] !== want.pole[k])
        report_mismatch($sformatf("multipole_l%0d", 2 * k), got[k], want.pole[k]);
    if (out_saturated !== want.clip)
      report_mismatch("saturated", 64'(out_saturated), 64'(want.clip));
    n_results++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_bins.delete();
      for (int k = 0; k < 5; k++) pole_sums[k] = 0;
      lin_pos = 0;
      log_pos = 0;
      clip_seen = 1'b0;
      lin_bins_reg = 7'd16;
      log_bins_reg = 7'd32;
    end else begin
      if (cfg_we) begin
        if (cfg_index == lmba_pkg::CFG_LIN_BINS) lin_bins_reg = cfg_wdata;
        else log_bins_reg = cfg_wdata;
      end
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) begin
        predict_word(in_pair_count, in_weighted_count, in_weighted_mu_sum);
        n_words++;
      end
    end
    fail_count    <= fails;
    pending_count <= expected_bins.size();
    results_seen  <= n_results;
    words_seen    <= n_words;
  end

endmodule

>>> sim/legendre_multipole_bin_accumulator_tb.sv
// ----------------------------------------------------------------------------
// Multipole accumulator testbench
// Drives directed and random fine bins through several register settings,
// with bursty input and a stalling receiver; the checker scores the results.
// ----------------------------------------------------------------------------
module legendre_multipole_bin_accumulator_tb;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 100;   // lets a trailing word retire

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [31:0]        in_pair_count;
  logic [47:0]        in_weighted_count;
  logic signed [48:0] in_weighted_mu_sum;
  logic               out_valid;
  logic               out_ready;
  logic [5:0]         out_log_bin_index;
  logic signed [63:0] out_multipole_l0;
  logic signed [63:0] out_multipole_l2;
  logic signed [63:0] out_multipole_l4;
  logic signed [63:0] out_multipole_l6;
  logic signed [63:0] out_multipole_l8;
  logic               out_saturated;
  logic               cfg_we;
  logic               cfg_index;
  logic [6:0]         cfg_wdata;

  int fail_count;
  int pending_count;
  int results_seen;
  int words_seen;
  int cycle_count = 0;
  int burst_left;

  legendre_multipole_bin_accumulator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_pair_count(in_pair_count), .in_weighted_count(in_weighted_count),
    .in_weighted_mu_sum(in_weighted_mu_sum),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_log_bin_index(out_log_bin_index),
    .out_multipole_l0(out_multipole_l0), .out_multipole_l2(out_multipole_l2),
    .out_multipole_l4(out_multipole_l4), .out_multipole_l6(out_multipole_l6),
    .out_multipole_l8(out_multipole_l8), .out_saturated(out_saturated),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  legendre_multipole_bin_accumulator_checker u_chk (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Abort on a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: rotate through three stall patterns set by the cycle count;
  // always-ready, coin-flip, and long periodic stalls.
  always @(posedge clk) begin
    case ((cycle_count >> 9) % 3)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      default: out_ready <= (cycle_count % 16) < 3;
    endcase
  end

  // Present one word and hold it until accepted; valid stays high afterwards
  // so back-to-back words need no extra edge. Bursts end with a random gap.
  task automatic send_word(logic [31:0] n, logic [47:0] wn, logic [48:0] wmu);
    int gap;
    in_valid           <= 1'b1;
    in_pair_count      <= n;
    in_weighted_count  <= wn;
    in_weighted_mu_sum <= wmu;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drop valid, wait for every expected result, then let trailing words
  // that produce no result finish inside the block.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_bins(logic [6:0] lin, logic [6:0] logv);
    cfg_we    <= 1'b1;
    cfg_index <= lmba_pkg::CFG_LIN_BINS;
    cfg_wdata <= lin;
    @(posedge clk);
    cfg_index <= lmba_pkg::CFG_LOG_BINS;
    cfg_wdata <= logv;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random fine bin: mostly a physical mu within [-1,1], sometimes beyond,
  // sometimes zero count or weight, sometimes raw full-width bits.
  task automatic send_random();
    logic [31:0] n;
    logic [47:0] wn;
    logic [48:0] wmu;
    logic [15:0] frac;
    n = $urandom();
    wn = 48'({$urandom(), $urandom()});
    if ($urandom_range(0, 1)) wn = wn >> $urandom_range(0, 40);
    frac = 16'($urandom());
    wmu = 49'((65'(wn) * 65'(frac)) >> 16);
    case ($urandom_range(0, 9))
      0: n = 0;
      1: wn = 0;
      2: wmu = 49'(wn) + 49'($urandom_range(0, 1000));
      3: wmu = 49'({$urandom(), $urandom()});
      default: ;
    endcase
    if ($urandom_range(0, 1)) wmu = -wmu;
    send_word(n, wn, wmu);
  endtask

  task automatic random_phase(logic [6:0] lin, logic [6:0] logv, int count);
    drain();
    write_bins(lin, logv);
    repeat (count) send_random();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pair_count = '0;
    in_weighted_count = '0;
    in_weighted_mu_sum = '0;
    cfg_we = 1'b0;
    cfg_index = lmba_pkg::CFG_LIN_BINS;
    cfg_wdata = '0;
    burst_left = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at reset settings (16 per log bin).
    send_word(32'd0, 48'h0001_0000, 49'h0_0000_8000);           // zero count
    send_word(32'd5, 48'd0, 49'h0_0000_8000);                   // zero weight
    send_word(32'd1, 48'h0001_0000, 49'h0_0002_0000);           // mu beyond +1
    send_word(32'd1, 48'h0001_0000, -49'sh0_0002_0000);         // mu beyond -1
    send_word(32'd1, 48'h0001_0000, 49'h0_0001_0000);           // mu exactly 1
    send_word(32'd1, 48'h0001_0000, -49'sh0_0001_0000);         // mu exactly -1
    send_word(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 49'h0_7FFF_FFFF_FFFF);
    send_word(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 49'h1_0000_0000_0000); // most neg
    send_word(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 49'h0);        // full weight, mu 0
    send_word(32'd7, 48'h0002_0000, 49'h0_0001_0000);           // mu one half
    send_word(32'd7, 48'h0003_0000, -49'sh0_0001_0000);         // mu minus a third
    send_word(32'd1, 48'd1, 49'd0);
    send_word(32'd1, 48'd3, 49'd1);
    send_word(32'h8000_0000, 48'h8000_0000_0000, 49'h0_4000_0000_0000);
    send_word(32'd2, 48'hFFFF_FFFF_FFFF, 49'h1_FFFF_FFFF_FFFF); // mu tiny neg
    send_word(32'd9, 48'h1234_5678_9ABC, 49'h1_8765_4321_0000);

    // Register extremes and out-of-range values, then random settings.
    random_phase(7'd1, 7'd1, 40);
    random_phase(7'd64, 7'd64, 128);
    random_phase(7'd0, 7'd0, 40);        // zero acts as one
    random_phase(7'd127, 7'd127, 64);    // above range acts as the maximum
    random_phase(7'd2, 7'd3, 50);
    drain();                              // sender holds until all results are in
    repeat (50) send_random();
    random_phase(7'd5, 7'd7, 80);
    for (int p = 0; p < 8; p++)
      random_phase(7'($urandom_range(1, 8)), 7'($urandom_range(1, 70)), 45);

    drain();
    $display("covered %0d input words and %0d log bin results", words_seen, results_seen);
    $display("settings swept: bin counts 0, 1, 2..8, 64 and 127 on both registers");
    if (fail_count == 0 && pending_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/lmba_pkg.sv
rtl/lmba_div.sv
rtl/legendre_multipole_bin_accumulator.sv
sim/legendre_multipole_bin_accumulator_checker.sv
sim/legendre_multipole_bin_accumulator_tb.sv
